// ===== sv/ecgdmx_pkg.sv =====
// Shared types and constants for the packed 12-bit ECG block demultiplexer.
`default_nettype none
package ecgdmx_pkg;

  // Width of a data offset inside a block (blocks are at most 8192 bytes).
  localparam int OFFS_W = 13;
  // Width of the next-start offset: a data offset plus an even-up step and a tail skip.
  localparam int NS_W = 14;
  // Width of the header data size as it is assembled from two bytes.
  localparam int DLEN_W = 16;
  // Width of the ECG sample counter within one macroblock.
  localparam int CNT_W = 11;
  // Width of the internal channel counter (one above the largest channel).
  localparam int CH_W = 4;

  localparam logic [3:0] NIBBLE_MASK = 4'hf;
  localparam logic [CNT_W-1:0] COUNT_CAP = 11'd2047;

  // Register map, in order of byte address.
  typedef enum logic [1:0] {
    REG_FRAMES   = 2'd0,
    REG_OFFSET   = 2'd1,
    REG_TAIL     = 2'd2,
    REG_MAX_SIZE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  ecg_frames_per_macroblock;
    logic [11:0] sample_offset;
    logic [7:0]  tail_bytes;
    logic [12:0] max_data_size;
  } cfg_t;

  // One classified byte handed from the front end to the back end.
  typedef struct packed {
    logic              restart;   // a new block began since the previous entry
    logic              reject;    // the header size was bad: emit a status beat
    logic              eligible;  // size known and offset within the data size
    logic [OFFS_W-1:0] offs;      // data offset of this byte
    logic [7:0]        data;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/ecgdmx_if.sv =====
// Valid/ready channel interfaces for raw block bytes and for results.
`default_nettype none
interface ecgdmx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source(output valid, data_byte, block_start, input ready);
  modport sink(input valid, data_byte, block_start, output ready);
endinterface

interface ecgdmx_res_if;
  logic              valid;
  logic              ready;
  logic signed [12:0] sample;
  logic [2:0]        channel;
  logic              status;

  modport source(output valid, sample, channel, status, input ready);
  modport sink(input valid, sample, channel, status, output ready);
endinterface
`default_nettype wire

// ===== sv/ecgdmx_front.sv =====
// Front end: tracks the byte position and header size and classifies every byte.
`default_nettype none
module ecgdmx_front #(
  parameter int HEADER_BYTES = 24,
  parameter int BLOCK_BYTES  = 4096,
  parameter int SIZE_HI_POS  = 0,
  parameter int SIZE_LO_POS  = 1
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ecgdmx_pkg::cfg_t     cfg,
  ecgdmx_byte_if.sink          raw,
  input  wire                  full,
  output logic                 push,
  output ecgdmx_pkg::entry_t   entry
);

  localparam int POS_W = $clog2(BLOCK_BYTES + 1);
  localparam int SIZE_DONE = (SIZE_HI_POS > SIZE_LO_POS) ? SIZE_HI_POS : SIZE_LO_POS;
  localparam logic [POS_W-1:0] BLOCK_END = POS_W'(BLOCK_BYTES);

  logic [POS_W-1:0]              pos, pos_next, pos_b;
  logic [ecgdmx_pkg::DLEN_W-1:0] dlen, dlen_next, dlen_b;
  logic                          rejected, rejected_next, rejected_b;
  logic                          pend, pend_next, pend_b;
  logic [31:0]                   pos32;
  logic                          fire, want_push, bad_size;

  assign raw.ready = !full;
  assign fire      = raw.valid && raw.ready;
  assign push      = fire && want_push;

  always_comb begin
    pos_b      = raw.block_start ? '0 : pos;
    dlen_b     = raw.block_start ? '0 : dlen;
    rejected_b = raw.block_start ? 1'b0 : rejected;
    pend_b     = raw.block_start | pend;
    pos32      = 32'(pos_b);

    pos_next      = pos_b;
    dlen_next     = dlen_b;
    rejected_next = rejected_b;
    pend_next     = pend_b;
    want_push     = 1'b0;
    bad_size      = 1'b0;

    entry          = '0;
    entry.restart  = pend_b;
    entry.data     = raw.data_byte;
    entry.offs     = ecgdmx_pkg::OFFS_W'(pos32 - 32'(HEADER_BYTES));

    if (pos_b < BLOCK_END) begin
      pos_next = pos_b + POS_W'(1);
      if (pos32 == 32'(SIZE_HI_POS)) dlen_next = {raw.data_byte, dlen_next[7:0]};
      if (pos32 == 32'(SIZE_LO_POS)) dlen_next = {dlen_next[15:8], raw.data_byte};
      bad_size = (dlen_next == '0) ||
                 (dlen_next > ecgdmx_pkg::DLEN_W'(cfg.max_data_size));
      if (pos32 == 32'(SIZE_DONE) && !rejected_b && bad_size) begin
        want_push     = 1'b1;
        entry.reject  = 1'b1;
        rejected_next = 1'b1;
      end else if (!rejected_b && pos32 >= 32'(HEADER_BYTES)) begin
        want_push      = 1'b1;
        entry.eligible = (pos32 >= 32'(SIZE_DONE)) &&
                         (ecgdmx_pkg::DLEN_W'(entry.offs) < dlen_next);
      end
    end
    if (want_push) pend_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      dlen     <= '0;
      rejected <= 1'b0;
      pend     <= 1'b0;
    end else if (fire) begin
      pos      <= pos_next;
      dlen     <= dlen_next;
      rejected <= rejected_next;
      pend     <= pend_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ecgdmx_fifo.sv =====
// Four-entry queue of classified bytes between the front and back ends.
`default_nettype none
module ecgdmx_fifo (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  ecgdmx_pkg::entry_t  push_data,
  output logic                full,
  input  wire                 pop,
  output ecgdmx_pkg::entry_t  pop_data,
  output logic                empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  ecgdmx_pkg::entry_t store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;

  assign full     = (count == (PTR_W+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/ecgdmx_back.sv =====
// Back end: unpacks 12-bit samples, assigns channels and holds the result register.
`default_nettype none
module ecgdmx_back #(
  parameter int ECG_CHANNELS   = 3,
  parameter int TOTAL_CHANNELS = 6
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ecgdmx_pkg::cfg_t    cfg,
  input  ecgdmx_pkg::entry_t  e,
  input  wire                 empty,
  output logic                pop,
  ecgdmx_res_if.source        result
);

  localparam logic [ecgdmx_pkg::CH_W-1:0]  ECG_CH   = ecgdmx_pkg::CH_W'(ECG_CHANNELS);
  localparam logic [ecgdmx_pkg::CH_W-1:0]  TOTAL_CH = ecgdmx_pkg::CH_W'(TOTAL_CHANNELS);
  localparam logic [ecgdmx_pkg::CNT_W-1:0] ECG_N    = ecgdmx_pkg::CNT_W'(ECG_CHANNELS);

  logic [ecgdmx_pkg::NS_W-1:0]  ns, ns_b, ns_n;
  logic                         phase, phase_b, phase_n;
  logic [7:0]                   held, held_b, held_n;
  logic [ecgdmx_pkg::CH_W-1:0]  ch, ch_b, ch_n;
  logic [ecgdmx_pkg::CNT_W-1:0] cnt, cnt_b, cnt_n;
  logic                         motion, motion_b, motion_n;
  logic [ecgdmx_pkg::CNT_W-1:0] ecg_total;
  logic [11:0]                  raw12;
  logic                         hit;

  logic               out_valid;
  logic [12:0]        out_sample;
  logic [2:0]         out_channel;
  logic               out_status;

  assign ecg_total = ecgdmx_pkg::CNT_W'(cfg.ecg_frames_per_macroblock) * ECG_N;
  assign pop       = !empty && (!out_valid || result.ready);

  always_comb begin
    ns_b     = e.restart ? '0 : ns;
    phase_b  = e.restart ? 1'b0 : phase;
    held_b   = e.restart ? '0 : held;
    ch_b     = e.restart ? '0 : ch;
    cnt_b    = e.restart ? '0 : cnt;
    motion_b = e.restart ? 1'b0 : motion;

    ns_n     = ns_b;
    phase_n  = phase_b;
    held_n   = e.reject ? held_b : e.data;
    ch_n     = ch_b;
    cnt_n    = cnt_b;
    motion_n = motion_b;

    hit   = !e.reject && e.eligible &&
            (ecgdmx_pkg::NS_W'(e.offs) == ns_b + ecgdmx_pkg::NS_W'(1));
    raw12 = phase_b ? {e.data, held_b[7:4]} : {e.data[3:0] & ecgdmx_pkg::NIBBLE_MASK, held_b};

    if (hit) begin
      ns_n    = ns_b + (phase_b ? ecgdmx_pkg::NS_W'(2) : ecgdmx_pkg::NS_W'(1));
      phase_n = !phase_b;
      ch_n    = ch_b + ecgdmx_pkg::CH_W'(1);
      if (!motion_b) begin
        if (ch_n >= ECG_CH) ch_n = '0;
        if (cnt_b < ecgdmx_pkg::COUNT_CAP) cnt_n = cnt_b + ecgdmx_pkg::CNT_W'(1);
        if (cnt_n == ecg_total) begin
          // Motion samples start on an even data offset.
          if (ns_n[0]) begin
            ns_n    = ns_n + ecgdmx_pkg::NS_W'(1);
            phase_n = 1'b0;
          end
          motion_n = 1'b1;
          ch_n     = ECG_CH;
        end
      end
      if (motion_n && ch_n >= TOTAL_CH) begin
        ch_n     = '0;
        cnt_n    = '0;
        motion_n = 1'b0;
        ns_n     = ns_n + ecgdmx_pkg::NS_W'(cfg.tail_bytes);
        phase_n  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ns     <= '0;
      phase  <= 1'b0;
      held   <= '0;
      ch     <= '0;
      cnt    <= '0;
      motion <= 1'b0;
    end else if (pop) begin
      ns     <= ns_n;
      phase  <= phase_n;
      held   <= held_n;
      ch     <= ch_n;
      cnt    <= cnt_n;
      motion <= motion_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && (e.reject || hit)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (e.reject || hit)) begin
      out_status  <= e.reject;
      out_sample  <= e.reject ? '0 : (13'(raw12) - 13'(cfg.sample_offset));
      out_channel <= e.reject ? '0 : ch_b[2:0];
    end
  end

  assign result.valid   = out_valid;
  assign result.sample  = $signed(out_sample);
  assign result.channel = out_channel;
  assign result.status  = out_status;

endmodule
`default_nettype wire

// ===== sv/ecg_block_12bit_demux_top.sv =====
// Top level of the packed 12-bit ECG block demultiplexer with its register port.
// The block takes one raw byte of an ECG data block per beat on the raw channel and
// returns at most one beat per byte on the result channel. A block begins at the byte
// flagged with block_start (after reset the first byte also counts as the start). The
// data size is read big-endian from two header positions; a size of zero or any size
// above max_data_size produces a single status beat (status 1, sample and channel 0)
// and the rest of that block is dropped. Data bytes hold pairs of 12-bit samples packed
// low-nibble first; each sample, less sample_offset, is returned as a signed 13-bit
// value with its channel, first the ECG channels round robin for the configured number
// of frames, then one sample per motion channel, after which tail_bytes bytes are
// skipped. Throughput is one byte per clock cycle, sustained, in both directions,
// while the result side does not stall. A byte travels through a classifying front
// end, a four-entry queue and an unpacking back end; the front end writes the byte's
// entry into the queue, and the back end pops it and loads the result register. A stall
// on the result side fills the queue and only then lowers raw.ready. Registers are
// written through the APB port and must only be changed while no byte is in flight.
`default_nettype none
module ecg_block_12bit_demux_top #(
  parameter int ECG_CHANNELS   = 3,
  parameter int TOTAL_CHANNELS = 6,
  parameter int HEADER_BYTES   = 24,
  parameter int BLOCK_BYTES    = 4096,
  parameter int SIZE_HI_POS    = 0,
  parameter int SIZE_LO_POS    = 1
) (
  input  wire          clk,
  input  wire          rst,
  ecgdmx_byte_if.sink  raw,
  ecgdmx_res_if.source result,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  ecgdmx_pkg::cfg_t     cfg;
  ecgdmx_pkg::reg_idx_t reg_idx;
  ecgdmx_pkg::entry_t   push_entry, pop_entry;
  logic                 push, pop, full, empty;
  logic                 reg_write;

  // The register port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_idx   = ecgdmx_pkg::reg_idx_t'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite && pready;

  // Configuration registers, reset to their documented defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ecg_frames_per_macroblock <= 8'd40;
      cfg.sample_offset             <= 12'd2048;
      cfg.tail_bytes                <= 8'd0;
      cfg.max_data_size             <= 13'd4072;
    end else if (reg_write) begin
      case (reg_idx)
        ecgdmx_pkg::REG_FRAMES:   cfg.ecg_frames_per_macroblock <= pwdata[7:0];
        ecgdmx_pkg::REG_OFFSET:   cfg.sample_offset             <= pwdata[11:0];
        ecgdmx_pkg::REG_TAIL:     cfg.tail_bytes                <= pwdata[7:0];
        ecgdmx_pkg::REG_MAX_SIZE: cfg.max_data_size             <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Read data is taken straight from the registers.
  always_comb begin
    case (reg_idx)
      ecgdmx_pkg::REG_FRAMES:   prdata = 32'(cfg.ecg_frames_per_macroblock);
      ecgdmx_pkg::REG_OFFSET:   prdata = 32'(cfg.sample_offset);
      ecgdmx_pkg::REG_TAIL:     prdata = 32'(cfg.tail_bytes);
      ecgdmx_pkg::REG_MAX_SIZE: prdata = 32'(cfg.max_data_size);
      default:                  prdata = '0;
    endcase
  end

  // The front end follows the block layout and tags every byte that the back end
  // must see: data bytes, with whether they fall inside the announced size, and the
  // single rejection beat. A block start is carried on the next tagged byte so that
  // the back end clears its unpacking state in step with the stream.
  ecgdmx_front #(
    .HEADER_BYTES(HEADER_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .SIZE_HI_POS (SIZE_HI_POS),
    .SIZE_LO_POS (SIZE_LO_POS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .raw  (raw),
    .full (full),
    .push (push),
    .entry(push_entry)
  );

  // The queue decouples the two halves so a result stall does not stop byte intake
  // until four tagged bytes are waiting.
  ecgdmx_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_entry),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_entry),
    .empty    (empty)
  );

  // The back end merges nibbles into samples, walks the channel order and drives the
  // result register, which is reloaded in the same cycle as it is emptied.
  ecgdmx_back #(
    .ECG_CHANNELS  (ECG_CHANNELS),
    .TOTAL_CHANNELS(TOTAL_CHANNELS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .e     (pop_entry),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

endmodule
`default_nettype wire

// ===== sv/ecgdmx_chk.sv =====
// Port-level checks for the ECG block demultiplexer and their binding to the top level.
`default_nettype none
module ecgdmx_chk #(
  parameter int TOTAL_CHANNELS = 6
) (
  input wire        clk,
  input wire        rst,
  input wire        res_valid,
  input wire        res_ready,
  input wire [12:0] res_sample,
  input wire [2:0]  res_channel,
  input wire        res_status,
  input wire        pready
);

  // A rejection beat carries no sample and channel zero.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_sample == 13'd0 && res_channel == 3'd0)
    else $error("status beat with non-zero sample or channel");

  // Sample beats only ever name an existing channel.
  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_status |-> 32'(res_channel) < TOTAL_CHANNELS)
    else $error("sample beat on a channel that does not exist");

  // A stalled result beat is held unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_sample) &&
      $stable(res_channel) && $stable(res_status))
    else $error("result beat changed while stalled");

  // The register port is always ready.
  a_pready: assert property (@(posedge clk) pready)
    else $error("register port inserted a wait state");

endmodule

bind ecg_block_12bit_demux_top ecgdmx_chk #(.TOTAL_CHANNELS(TOTAL_CHANNELS)) u_chk (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_sample (result.sample),
  .res_channel(result.channel),
  .res_status (result.status),
  .pready     (pready)
);
`default_nettype wire
